/* rtl/lmx_pkg.sv */
// Shared types and constants for the Lamport mutual exclusion node.
// Used by every module of the block except lmx_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lmx_pkg;

  localparam int MAX_NODES  = 16;
  localparam int TIME_BITS  = 32;
  localparam int RANK_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = RANK_W + 1;
  localparam int KIND_W     = 3;
  localparam int MSG_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  // event kinds on the input
  localparam logic [KIND_W-1:0] KIND_LREQ = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LREL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PREQ = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PREL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POK  = 3'd4;

  // outgoing message types
  localparam logic [MSG_W-1:0] MSG_REQ = 2'd0;
  localparam logic [MSG_W-1:0] MSG_REL = 2'd1;
  localparam logic [MSG_W-1:0] MSG_OK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MY_RANK    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LREQ,
    OP_LREL,
    OP_PREQ,
    OP_PREL,
    OP_POK
  } op_e;

  typedef struct packed {
    op_e                  code;
    logic [RANK_W-1:0]    peer;
    logic [TIME_BITS-1:0] ptime;
  } op_t;

  typedef struct packed {
    logic [RANK_W-1:0] my_rank;
    logic [CNT_W-1:0]  eff_m1;   // effective node count minus one
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [MSG_W-1:0]     kind;
    logic                 all;
    logic [RANK_W-1:0]    dest;
    logic [TIME_BITS-1:0] stime;
    logic                 granted;
  } res_t;

endpackage

`default_nettype wire

/* rtl/lmx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lmx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/lmx_front.sv */
// Front end: configuration registers and event classification.
// Depends on lmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmx_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lmx_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [lmx_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               push,
  input  wire logic [lmx_pkg::KIND_W-1:0]         kind_i,
  input  wire logic [lmx_pkg::RANK_W-1:0]         peer_i,
  input  wire logic [lmx_pkg::TIME_BITS-1:0]      peer_time_i,
  output logic                                    q_push_o,
  output lmx_pkg::op_t                            q_data_o,
  output lmx_pkg::cfg_t                           cfg_o
);

  logic [lmx_pkg::RANK_W-1:0] my_rank_q;
  logic [lmx_pkg::CNT_W-1:0]  node_count_q;
  logic [lmx_pkg::CNT_W-1:0]  eff_m1;
  logic                       peer_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_rank_q    <= '0;
      node_count_q <= lmx_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmx_pkg::CFG_MY_RANK:    my_rank_q    <= cfg_data_i[lmx_pkg::RANK_W-1:0];
        lmx_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i[lmx_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // node count 0 acts as 1, anything above the table size as the table size
  always_comb begin
    if (node_count_q == '0) begin
      eff_m1 = '0;
    end else if (node_count_q > lmx_pkg::CNT_W'(lmx_pkg::MAX_NODES)) begin
      eff_m1 = lmx_pkg::CNT_W'(lmx_pkg::MAX_NODES - 1);
    end else begin
      eff_m1 = node_count_q - lmx_pkg::CNT_W'(1);
    end
  end

  assign peer_ok = (peer_i != my_rank_q) && ({1'b0, peer_i} <= eff_m1);

  always_comb begin
    q_data_o.peer  = peer_i;
    q_data_o.ptime = peer_time_i;
    unique case (kind_i)
      lmx_pkg::KIND_LREQ: q_data_o.code = lmx_pkg::OP_LREQ;
      lmx_pkg::KIND_LREL: q_data_o.code = lmx_pkg::OP_LREL;
      lmx_pkg::KIND_PREQ: q_data_o.code = peer_ok ? lmx_pkg::OP_PREQ : lmx_pkg::OP_NOP;
      lmx_pkg::KIND_PREL: q_data_o.code = peer_ok ? lmx_pkg::OP_PREL : lmx_pkg::OP_NOP;
      lmx_pkg::KIND_POK:  q_data_o.code = peer_ok ? lmx_pkg::OP_POK  : lmx_pkg::OP_NOP;
      default:            q_data_o.code = lmx_pkg::OP_NOP;
    endcase
  end

  assign q_push_o       = push;
  assign cfg_o.my_rank  = my_rank_q;
  assign cfg_o.eff_m1   = eff_m1;

endmodule

`default_nettype wire

/* rtl/lmx_queue.sv */
// Short FIFO of classified events between front end and back end.
// Depends on lmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmx_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  lmx_pkg::op_t      data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output lmx_pkg::op_t      head_o,
  output logic              empty_o
);

  lmx_pkg::op_t               slot_q [lmx_pkg::QUEUE_DEPTH];
  logic [lmx_pkg::QPTR_W-1:0] wr_ptr_q;
  logic [lmx_pkg::QPTR_W-1:0] rd_ptr_q;
  logic [lmx_pkg::QCNT_W-1:0] count_q;
  logic                       do_push;
  logic                       do_pop;

  assign full_o  = (count_q == lmx_pkg::QCNT_W'(lmx_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + lmx_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + lmx_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + lmx_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - lmx_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/lmx_back.sv */
// Back end: request table, logical clock, grant scan and result register.
// Depends on lmx_pkg and lmx_ram.
`timescale 1ns / 1ps
`default_nettype none

module lmx_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  lmx_pkg::cfg_t cfg_i,
  input  lmx_pkg::op_t  q_head_i,
  input  wire logic     q_empty_i,
  output logic          q_pop_o,
  output lmx_pkg::res_t res_o,
  output logic          res_valid_o,
  input  wire logic     res_pop_i
);

  localparam int RW = lmx_pkg::RANK_W;
  localparam int TW = lmx_pkg::TIME_BITS;
  localparam int OW = lmx_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OWN_RD,
    ST_OWN_LAT,
    ST_SCAN
  } state_e;

  state_e                       state_q;
  lmx_pkg::op_t                 op_q;
  logic [lmx_pkg::MAX_NODES-1:0] pend_q, pend_d;
  logic [TW-1:0]                clock_q, clock_d;
  logic [TW-1:0]                hs_q, hs_d;
  logic [OW-1:0]                ok_q, ok_d;
  logic                         waiting_q, waiting_d;
  lmx_pkg::res_t                res_q, res_d;
  lmx_pkg::res_t                out_q;
  logic                         out_valid_q;
  logic [TW-1:0]                own_t_q;
  logic [OW-1:0]                cnt_q;
  logic                         rv_q;
  logic [RW-1:0]                ridx_q;
  logic                         lose_q;

  logic [RW-1:0] own;
  logic          accepted;
  logic          cand;
  logic          wr_en;
  logic [RW-1:0] wr_addr;
  logic [TW-1:0] wr_data;
  logic [TW-1:0] rel_next;
  logic [RW-1:0] rd_addr;
  logic [TW-1:0] rd_data;
  logic          hit;
  logic          scan_done;
  logic          lose_all;
  lmx_pkg::res_t grant_res;

  assign own = cfg_i.my_rank;

  // state update for the event at the back end
  always_comb begin
    clock_d   = clock_q;
    hs_d      = hs_q;
    ok_d      = ok_q;
    waiting_d = waiting_q;
    pend_d    = pend_q;
    res_d     = '0;
    wr_en     = 1'b0;
    wr_addr   = own;
    wr_data   = clock_q;
    accepted  = 1'b0;
    rel_next  = hs_q + TW'(1);
    unique case (op_q.code) inside
      lmx_pkg::OP_LREQ: begin
        if (!pend_q[own]) begin
          clock_d       = clock_q + TW'(1);
          pend_d[own]   = 1'b1;
          wr_en         = 1'b1;
          wr_data       = clock_d;
          ok_d          = '0;
          waiting_d     = 1'b1;
          res_d.valid   = 1'b1;
          res_d.kind    = lmx_pkg::MSG_REQ;
          res_d.all     = 1'b1;
          res_d.stime   = clock_d;
          accepted      = 1'b1;
        end
      end
      lmx_pkg::OP_LREL: begin
        if (pend_q[own] && !waiting_q) begin
          pend_d[own]   = 1'b0;
          res_d.valid   = 1'b1;
          res_d.kind    = lmx_pkg::MSG_REL;
          res_d.all     = 1'b1;
          res_d.stime   = clock_q;
          if (rel_next > clock_q) begin
            clock_d = rel_next;
          end
          accepted      = 1'b1;
        end
      end
      lmx_pkg::OP_PREQ, lmx_pkg::OP_PREL, lmx_pkg::OP_POK: begin
        if (op_q.ptime > hs_q) begin
          hs_d = op_q.ptime;
        end
        if (op_q.code == lmx_pkg::OP_PREQ) begin
          pend_d[op_q.peer] = 1'b1;
          wr_en             = 1'b1;
          wr_addr           = op_q.peer;
          wr_data           = op_q.ptime;
          res_d.valid       = 1'b1;
          res_d.kind        = lmx_pkg::MSG_OK;
          res_d.dest        = op_q.peer;
          res_d.stime       = clock_q;
        end else if (op_q.code == lmx_pkg::OP_PREL) begin
          pend_d[op_q.peer] = 1'b0;
        end else if (ok_q != '1) begin
          ok_d = ok_q + OW'(1);
        end
        accepted = 1'b1;
      end
      default: ;
    endcase
    cand = accepted && waiting_d && (ok_d == cfg_i.eff_m1) && pend_d[own];
  end

  assign rd_addr = (state_q == ST_SCAN) ? cnt_q[RW-1:0] : own;

  lmx_ram #(
    .WIDTH (TW),
    .DEPTH (lmx_pkg::MAX_NODES)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en && (state_q == ST_EXEC)),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // another pending entry ordered before ours by (time, rank)
  assign hit = rv_q && pend_q[ridx_q] && (ridx_q != own) &&
               ((rd_data < own_t_q) || ((rd_data == own_t_q) && (ridx_q < own)));
  assign scan_done = (state_q == ST_SCAN) && cnt_q[RW] && rv_q;
  assign lose_all  = lose_q || hit;

  always_comb begin
    grant_res         = res_q;
    grant_res.granted = !lose_all;
  end

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      pend_q      <= '0;
      clock_q     <= '0;
      hs_q        <= '0;
      ok_q        <= '0;
      waiting_q   <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      own_t_q     <= '0;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      ridx_q      <= '0;
      lose_q      <= 1'b0;
    end else begin
      if (res_pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            op_q    <= q_head_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          clock_q   <= clock_d;
          hs_q      <= hs_d;
          ok_q      <= ok_d;
          waiting_q <= waiting_d;
          pend_q    <= pend_d;
          res_q     <= res_d;
          if (cand) begin
            state_q <= ST_OWN_RD;
          end else begin
            out_q       <= res_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_OWN_RD: begin
          state_q <= ST_OWN_LAT;
        end
        ST_OWN_LAT: begin
          own_t_q <= rd_data;
          cnt_q   <= '0;
          rv_q    <= 1'b0;
          lose_q  <= 1'b0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!cnt_q[RW]) begin
            rv_q   <= 1'b1;
            ridx_q <= cnt_q[RW-1:0];
            cnt_q  <= cnt_q + OW'(1);
          end else begin
            rv_q <= 1'b0;
          end
          if (hit) begin
            lose_q <= 1'b1;
          end
          if (scan_done) begin
            out_q         <= grant_res;
            waiting_q     <= lose_all;
            out_valid_q   <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  // the back end only works on an event while the result slot is free
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("back end busy while result slot occupied");

  // a grant always clears the waiting flag
  a_grant_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_done && !lose_all) |=> !waiting_q)
    else $error("waiting still set after grant");

  // a granted node holds its own request entry
  a_grant_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.granted) |-> pend_q[own] || !$stable(out_q))
    else $error("grant without own pending entry");

  // no message means an all-zero message word
  a_idle_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.valid) |-> (out_q.stime == '0) && (out_q.kind == lmx_pkg::MSG_REQ)
      && !out_q.all && (out_q.dest == '0))
    else $error("message fields set without a message");

endmodule

`default_nettype wire

/* rtl/lamport_mutex_node.sv */
// Top level of one Lamport mutual exclusion node.
// Depends on lmx_pkg, lmx_front, lmx_queue and lmx_back.
`timescale 1ns / 1ps
`default_nettype none

// Every accepted event yields exactly one result item, in order. Events enter
// a two-item queue (full rises when it holds two); the back end then takes
// one event at a time. An event that cannot lead to a grant is moved from the
// queue head into the op register and its result is written from the execute
// state. When the node is waiting, has all OKs and its own entry is pending,
// the back end scans the 16-entry timestamp RAM one entry per cycle through
// its single registered read port before it writes the result.
// The back end starts the next event only once the result register is empty.
// Configuration writes take effect at once and are meant for an idle node.
module lamport_mutex_node (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lmx_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lmx_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [lmx_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [lmx_pkg::RANK_W-1:0]      peer_i,
  input  wire logic [lmx_pkg::TIME_BITS-1:0]   peer_time_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 send_valid_o,
  output logic [lmx_pkg::MSG_W-1:0]            send_kind_o,
  output logic                                 send_all_o,
  output logic [lmx_pkg::RANK_W-1:0]           send_dest_o,
  output logic [lmx_pkg::TIME_BITS-1:0]        send_time_o,
  output logic                                 granted_o
);

  lmx_pkg::cfg_t cfg;
  lmx_pkg::op_t  q_in;
  lmx_pkg::op_t  q_head;
  lmx_pkg::res_t res;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          res_valid;

  lmx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .kind_i      (kind_i),
    .peer_i      (peer_i),
    .peer_time_i (peer_time_i),
    .q_push_o    (q_push),
    .q_data_o    (q_in),
    .cfg_o       (cfg)
  );

  lmx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  lmx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_head_i    (q_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty        = !res_valid;
  assign send_valid_o = res.valid;
  assign send_kind_o  = res.kind;
  assign send_all_o   = res.all;
  assign send_dest_o  = res.dest;
  assign send_time_o  = res.stime;
  assign granted_o    = res.granted;

endmodule

`default_nettype wire

/* tb/sv/lmx_grant_checker.sv */
// Scoreboard for the Lamport mutex node: tracks config writes, predicts each result item.
// Compares results field by field in order. Depends on lmx_pkg.
`timescale 1ns / 1ps

module lmx_grant_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lmx_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lmx_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic [lmx_pkg::KIND_W-1:0]      kind_i,
  input  logic [lmx_pkg::RANK_W-1:0]      peer_i,
  input  logic [lmx_pkg::TIME_BITS-1:0]   peer_time_i,
  input  logic                            empty_i,
  input  logic                            pop_i,
  input  logic                            send_valid_i,
  input  logic [lmx_pkg::MSG_W-1:0]       send_kind_i,
  input  logic                            send_all_i,
  input  logic [lmx_pkg::RANK_W-1:0]      send_dest_i,
  input  logic [lmx_pkg::TIME_BITS-1:0]   send_time_i,
  input  logic                            granted_i,
  output int unsigned                     backlog_o,
  output int unsigned                     mismatches_o
);
  import lmx_pkg::*;

  // shadow of the node state
  logic                 pend_tbl  [MAX_NODES];
  logic [TIME_BITS-1:0] stamp_tbl [MAX_NODES];
  logic [TIME_BITS-1:0] lclock;
  logic [TIME_BITS-1:0] max_seen;
  logic [CNT_W-1:0]     oks;
  logic                 in_wait;
  logic [RANK_W-1:0]    rank_reg;
  logic [CNT_W-1:0]     count_reg;

  res_t        expected_msgs[$];
  res_t        want_msg;
  int unsigned mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic int live_nodes();
    if (count_reg == '0) return 1;
    if (count_reg > MAX_NODES) return MAX_NODES;
    return int'(count_reg);
  endfunction

  // own entry is least by (time, rank) among pending entries
  function automatic logic holds_lead(int own);
    if (!pend_tbl[own]) return 1'b0;
    for (int j = 0; j < MAX_NODES; j++) begin
      if (j != own && pend_tbl[j]) begin
        if (stamp_tbl[j] < stamp_tbl[own]) return 1'b0;
        if (stamp_tbl[j] == stamp_tbl[own] && j < own) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic res_t apply_event(logic [KIND_W-1:0] k, logic [RANK_W-1:0] p,
                                       logic [TIME_BITS-1:0] t);
    res_t                 r;
    logic                 taken;
    logic [TIME_BITS-1:0] bumped;
    int                   own;
    r     = '0;
    taken = 1'b0;
    own   = int'(rank_reg);
    if (k == KIND_LREQ) begin
      if (!pend_tbl[own]) begin
        lclock         = lclock + 1'b1;
        pend_tbl[own]  = 1'b1;
        stamp_tbl[own] = lclock;
        oks            = '0;
        in_wait        = 1'b1;
        r.valid        = 1'b1;
        r.kind         = MSG_REQ;
        r.all          = 1'b1;
        r.stime        = lclock;
        taken          = 1'b1;
      end
    end else if (k == KIND_LREL) begin
      if (pend_tbl[own] && !in_wait) begin
        bumped        = max_seen + 1'b1;
        pend_tbl[own] = 1'b0;
        r.valid       = 1'b1;
        r.kind        = MSG_REL;
        r.all         = 1'b1;
        r.stime       = lclock;
        if (bumped > lclock) lclock = bumped;
        taken         = 1'b1;
      end
    end else if ((k == KIND_PREQ || k == KIND_PREL || k == KIND_POK) &&
                 p != rank_reg && int'(p) < live_nodes()) begin
      if (t > max_seen) max_seen = t;
      taken = 1'b1;
      case (k)
        KIND_PREQ: begin
          pend_tbl[p]  = 1'b1;
          stamp_tbl[p] = t;
          r.valid      = 1'b1;
          r.kind       = MSG_OK;
          r.dest       = p;
          r.stime      = lclock;
        end
        KIND_PREL: pend_tbl[p] = 1'b0;
        default: if (oks != '1) oks = oks + 1'b1;
      endcase
    end
    if (taken && in_wait && int'(oks) == live_nodes() - 1 && holds_lead(own)) begin
      in_wait   = 1'b0;
      r.granted = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TIME_BITS-1:0] want,
                             input logic [TIME_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        pend_tbl[i]  = 1'b0;
        stamp_tbl[i] = '0;
      end
      lclock    = '0;
      max_seen  = '0;
      oks       = '0;
      in_wait   = 1'b0;
      rank_reg  = '0;
      count_reg = CNT_W'(1);
      expected_msgs.delete();
      backlog_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MY_RANK) rank_reg = cfg_data_i[RANK_W-1:0];
        else if (cfg_idx_i == CFG_NODE_COUNT) count_reg = cfg_data_i[CNT_W-1:0];
      end
      if (pop_i && !empty_i) begin
        if (expected_msgs.size() == 0) begin
          $error("result item with nothing expected");
          mismatches++;
        end else begin
          want_msg = expected_msgs.pop_front();
          check_field("send_valid", want_msg.valid, send_valid_i);
          check_field("send_kind", want_msg.kind, send_kind_i);
          check_field("send_all", want_msg.all, send_all_i);
          check_field("send_dest", want_msg.dest, send_dest_i);
          check_field("send_time", want_msg.stime, send_time_i);
          check_field("granted", want_msg.granted, granted_i);
        end
      end
      if (push_i && !full_i) begin
        expected_msgs.insert(expected_msgs.size(), apply_event(kind_i, peer_i, peer_time_i));
      end
      backlog_o <= expected_msgs.size();
    end
  end

endmodule

/* tb/sv/tb_lamport_mutex_node.sv */
// Top of the Lamport mutex node testbench: clock, reset, event stimulus and verdict.
// Depends on lmx_pkg, lamport_mutex_node and lmx_grant_checker.
`timescale 1ns / 1ps

module tb_lamport_mutex_node;
  import lmx_pkg::*;

  localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;
  // worst legit gap is the long receiver hold-off; allow many times that
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [KIND_W-1:0]     kind_i = '0;
  logic [RANK_W-1:0]     peer_i = '0;
  logic [TIME_BITS-1:0]  peer_time_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  send_valid_o;
  logic [MSG_W-1:0]      send_kind_o;
  logic                  send_all_o;
  logic [RANK_W-1:0]     send_dest_o;
  logic [TIME_BITS-1:0]  send_time_o;
  logic                  granted_o;

  int unsigned backlog;
  int unsigned mismatches;

  int tx_idle = 17;
  int rx_idle = 59;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  // what the stimulus knows of the current setup
  int                   cur_rank = 0;
  int                   cur_eff = 1;
  logic [MAX_NODES-1:0] open_reqs = '0;
  int                   session_items = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lamport_mutex_node dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .peer_i       (peer_i),
    .peer_time_i  (peer_time_i),
    .empty        (empty),
    .pop          (pop),
    .send_valid_o (send_valid_o),
    .send_kind_o  (send_kind_o),
    .send_all_o   (send_all_o),
    .send_dest_o  (send_dest_o),
    .send_time_o  (send_time_o),
    .granted_o    (granted_o)
  );

  lmx_grant_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .full_i       (full),
    .kind_i       (kind_i),
    .peer_i       (peer_i),
    .peer_time_i  (peer_time_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .send_valid_i (send_valid_o),
    .send_kind_i  (send_kind_o),
    .send_all_i   (send_all_o),
    .send_dest_i  (send_dest_o),
    .send_time_i  (send_time_o),
    .granted_i    (granted_o),
    .backlog_o    (backlog),
    .mismatches_o (mismatches)
  );

  // result side: random pops, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      pop <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [TIME_BITS-1:0] rand_stamp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return TIME_BITS'($urandom_range(0, 255));
      default: return TIME_BITS'($urandom());
    endcase
  endfunction

  function automatic int clamp_nodes(logic [CNT_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_NODES) return MAX_NODES;
    return int'(raw);
  endfunction

  task automatic send_event(input logic [KIND_W-1:0] k, input logic [RANK_W-1:0] p,
                            input logic [TIME_BITS-1:0] t);
    while ($urandom_range(0, 99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    kind_i      <= k;
    peer_i      <= p;
    peer_time_i <= t;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    session_items++;
  endtask

  // wait until every expected result item has been taken
  task automatic settle_node();
    push <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
  endtask

  task automatic program_node(input logic [RANK_W-1:0] rank, input logic [CNT_W-1:0] raw);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MY_RANK;
    cfg_data_i <= CFG_DATA_W'(rank);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_NODE_COUNT;
    cfg_data_i <= CFG_DATA_W'(raw);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_rank = int'(rank);
    cur_eff  = clamp_nodes(raw);
  endtask

  task automatic pick_setting();
    logic [CNT_W-1:0]  raw;
    logic [RANK_W-1:0] rank;
    case ($urandom_range(0, 9))
      0:       raw = '0;
      1:       raw = CNT_W'(1);
      2:       raw = CNT_W'(MAX_NODES);
      3:       raw = CNT_W'($urandom_range(MAX_NODES + 1, 31));
      default: raw = CNT_W'($urandom_range(2, 5));
    endcase
    if ($urandom_range(0, 4) == 0) rank = RANK_W'($urandom());
    else rank = RANK_W'($urandom_range(0, clamp_nodes(raw) - 1));
    settle_node();
    program_node(rank, raw);
  endtask

  // events the node must ignore while its own request is open
  task automatic send_stray();
    case ($urandom_range(0, 3))
      0: send_event(KIND_W'($urandom_range(KIND_BAD_LO, KIND_BAD_HI)), RANK_W'($urandom()),
                    rand_stamp());
      1: send_event(KIND_W'($urandom_range(KIND_PREQ, KIND_POK)), RANK_W'(cur_rank),
                    rand_stamp());
      2: if (cur_eff < MAX_NODES)
           send_event(KIND_W'($urandom_range(KIND_PREQ, KIND_POK)),
                      RANK_W'($urandom_range(cur_eff, MAX_NODES - 1)), rand_stamp());
         else
           send_event(KIND_LREQ, RANK_W'($urandom()), rand_stamp());
      default: send_event(KIND_LREQ, RANK_W'($urandom()), rand_stamp());
    endcase
  endtask

  // junk between requests; peer REQs that land are remembered for cleanup
  task automatic send_noise();
    logic [KIND_W-1:0] k;
    logic [RANK_W-1:0] p;
    int                flood_peer;
    if (cur_eff >= 2 && $urandom_range(0, 39) == 0) begin
      flood_peer = (cur_rank == 0) ? 1 : 0;
      // enough OKs to pin the counter at its ceiling
      repeat (35) send_event(KIND_POK, RANK_W'(flood_peer), rand_stamp());
    end
    repeat ($urandom_range(0, 3)) begin
      k = KIND_W'($urandom_range(KIND_LREL, KIND_BAD_HI));
      p = RANK_W'($urandom());
      send_event(k, p, rand_stamp());
      if (int'(p) != cur_rank && int'(p) < cur_eff) begin
        if (k == KIND_PREQ) open_reqs[p] = 1'b1;
        else if (k == KIND_PREL) open_reqs[p] = 1'b0;
      end
    end
  endtask

  // one full request: REQ out, OKs (some peers also request), releases, then own release
  task automatic run_request();
    int order[$];
    int pick;
    int tmp;
    send_event(KIND_LREQ, RANK_W'($urandom()), rand_stamp());
    for (int p = 0; p < cur_eff; p++) if (p != cur_rank) order.insert(order.size(), p);
    for (int j = order.size() - 1; j > 0; j--) begin
      pick = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[pick];
      order[pick] = tmp;
    end
    // a rank outside the group still needs exactly count - 1 OKs
    while (order.size() > cur_eff - 1) void'(order.pop_back());
    foreach (order[j]) begin
      if ($urandom_range(0, 3) == 0) begin
        send_event(KIND_PREQ, RANK_W'(order[j]), rand_stamp());
        open_reqs[order[j]] = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) send_stray();
      send_event(KIND_POK, RANK_W'(order[j]), rand_stamp());
    end
    for (int p = 0; p < MAX_NODES; p++) begin
      if (open_reqs[p]) begin
        send_event(KIND_PREL, RANK_W'(p), rand_stamp());
      end
    end
    open_reqs = '0;
    send_event(KIND_LREL, RANK_W'($urandom()), rand_stamp());
  endtask

  initial begin
    int sessions;
    sessions = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone node at reset setup: immediate grant, repeats and misdirected events
    send_event(KIND_LREQ, RANK_W'($urandom()), rand_stamp());
    send_event(KIND_LREQ, RANK_W'($urandom()), rand_stamp());
    send_event(KIND_PREQ, RANK_W'(1), TIME_BITS'(5));
    send_event(KIND_PREQ, RANK_W'(0), TIME_BITS'(5));
    send_event(KIND_LREL, RANK_W'($urandom()), rand_stamp());
    send_event(KIND_LREL, RANK_W'($urandom()), rand_stamp());
    send_event(KIND_BAD_LO, RANK_W'($urandom()), rand_stamp());
    send_event(KIND_BAD_HI, RANK_W'($urandom()), rand_stamp());
    settle_node();
    program_node(RANK_W'(15), CNT_W'(31));
    send_event(KIND_PREQ, RANK_W'(15), '1);
    send_event(KIND_PREQ, RANK_W'(0), '1);
    send_event(KIND_PREL, RANK_W'(0), '0);
    send_event(KIND_POK, RANK_W'(14), '0);
    settle_node();
    // tie on time lost to a lower rank, then a duplicate OK
    program_node(RANK_W'(2), CNT_W'(3));
    send_event(KIND_LREQ, RANK_W'($urandom()), rand_stamp());
    send_event(KIND_PREQ, RANK_W'(1), TIME_BITS'(2));
    send_event(KIND_POK, RANK_W'(0), TIME_BITS'(3));
    send_event(KIND_POK, RANK_W'(1), '0);
    send_event(KIND_POK, RANK_W'(0), TIME_BITS'(4));
    send_event(KIND_PREL, RANK_W'(1), '0);
    settle_node();
    // larger group makes the extra OK count; release wraps the clock bump
    program_node(RANK_W'(2), CNT_W'(4));
    send_event(KIND_PREL, RANK_W'(0), '0);
    send_event(KIND_LREL, RANK_W'($urandom()), rand_stamp());
    // tie on time won against a higher rank
    send_event(KIND_LREQ, RANK_W'($urandom()), rand_stamp());
    send_event(KIND_PREQ, RANK_W'(3), TIME_BITS'(3));
    send_event(KIND_POK, RANK_W'(0), '0);
    send_event(KIND_POK, RANK_W'(1), '0);
    send_event(KIND_POK, RANK_W'(3), '0);
    send_event(KIND_PREL, RANK_W'(3), '0);
    send_event(KIND_LREL, RANK_W'($urandom()), rand_stamp());

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle = 17; rx_idle <= 59; end
        1: begin tx_idle = 59; rx_idle <= 17; end
        default: begin
          tx_idle = 0;
          rx_idle <= 0;
          hold_req <= hold_req + 1;
        end
      endcase
      while (session_items < (phase + 1) * PHASE_ITEMS) begin
        if (sessions % 6 == 0) pick_setting();
        send_noise();
        run_request();
        sessions++;
      end
    end

    settle_node();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* lamport_mutex_node.f */
rtl/lmx_pkg.sv
rtl/lmx_ram.sv
rtl/lmx_front.sv
rtl/lmx_queue.sv
rtl/lmx_back.sv
rtl/lamport_mutex_node.sv
tb/sv/lmx_grant_checker.sv
tb/sv/tb_lamport_mutex_node.sv
